@@ rtl/htint_pkg.sv @@
// ----------------------------------------------------------------------------
// htint_pkg
// Shared types and constants for the humidity/temperature interpolator.
// ----------------------------------------------------------------------------
package htint_pkg;

  localparam int SAMPLE_W = 16;           // raw sample and raw calibration counts
  localparam int CFG_W    = 16;           // widest calibration register
  localparam int CFG_IDX_W = 3;
  localparam int OPND_W   = 18;           // multiplier operand width
  localparam int PROD_W   = 2 * OPND_W;
  localparam int DIV_W    = 33;           // dividend magnitude width
  localparam int DVS_W    = 16;           // divisor magnitude width

  // window limits in Q8.8
  localparam logic [OPND_W-1:0] MAX_Q      = OPND_W'(25600); // 100 (both)
  localparam logic [OPND_W-1:0] TEMP_MIN_Q = OPND_W'(15360); // magnitude of -60

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL0_DEG = 3'd0,
    REG_TEMP_CAL1_DEG = 3'd1,
    REG_TEMP_CAL0_RAW = 3'd2,
    REG_TEMP_CAL1_RAW = 3'd3,
    REG_HUM_CAL0_RH   = 3'd4,
    REG_HUM_CAL1_RH   = 3'd5,
    REG_HUM_CAL0_RAW  = 3'd6,
    REG_HUM_CAL1_RAW  = 3'd7
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MUL_A    = 7'b0000010,
    ST_MUL_B    = 7'b0000100,
    ST_MUL_C    = 7'b0001000,
    ST_MUL_D    = 7'b0010000,
    ST_DIV_WAIT = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  // divider handshake towards the sequencer
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

@@ rtl/htint_chan_if.sv @@
// ----------------------------------------------------------------------------
// htint_chan_if
// Valid/ready channels for raw samples and converted results.
// ----------------------------------------------------------------------------
interface htint_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] raw_sample;

  modport source (output valid, output func, output raw_sample, input ready);
  modport sink   (input valid, input func, input raw_sample, output ready);
endinterface

interface htint_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] converted;
  logic               accepted;
  logic               divide_fault;
  logic signed [15:0] held_value;

  modport source (output valid, output kind, output converted, output accepted,
                  output divide_fault, output held_value, input ready);
  modport sink   (input valid, input kind, input converted, input accepted,
                  input divide_fault, input held_value, output ready);
endinterface

@@ rtl/humidity_temperature_interpolator.sv @@
// ----------------------------------------------------------------------------
// humidity_temperature_interpolator
// The sequencer steps through the shared multiplier and then waits on the 33-step
// divider; an equal raw pair skips to the final step. One sample is in work at a
// time, and a stalled result holds the sequencer in its last step.
// rst (synchronous) clears calibration, last readings and the sequencer.
// Two-point linear calibration of raw humidity/temperature samples to Q8.8.
// ----------------------------------------------------------------------------
module humidity_temperature_interpolator import htint_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  htint_in_if.sink             sample,
  htint_out_if.source          result
);

  // calibration registers
  logic [9:0]  temp_cal0_deg_x8, temp_cal1_deg_x8;
  logic [15:0] temp_cal0_raw, temp_cal1_raw;
  logic [7:0]  hum_cal0_rh_x2, hum_cal1_rh_x2;
  logic [15:0] hum_cal0_raw, hum_cal1_raw;

  // last good readings, Q8.8
  logic [15:0] last_humidity, last_temperature;

  state_t state;

  // per-sample working registers
  logic               kind;
  logic               fault;
  logic signed [16:0] dr;      // raw - r0
  logic signed [16:0] den;     // r1 - r0
  logic signed [7:0]  dp;      // p1 - p0 (whole units)
  logic [6:0]         p0;
  logic [DVS_W-1:0]   aden;    // |den|
  logic signed [25:0] prod1;
  logic signed [25:0] sum;     // (raw-r0)*dp + p0*den
  logic signed [33:0] num;     // 256*sum, sign folded so divisor is positive
  logic [31:0]        lim_hi;
  logic [31:0]        lim_lo;

  // accept-time selection of calibration set
  logic signed [15:0] sel_r0, sel_r1;
  logic [6:0]         sel_p0, sel_p1;

  always_comb begin
    if (sample.func) begin
      sel_r0 = temp_cal0_raw;
      sel_r1 = temp_cal1_raw;
      sel_p0 = temp_cal0_deg_x8[9:3];
      sel_p1 = temp_cal1_deg_x8[9:3];
    end else begin
      sel_r0 = hum_cal0_raw;
      sel_r1 = hum_cal1_raw;
      sel_p0 = hum_cal0_rh_x2[7:1];
      sel_p1 = hum_cal1_rh_x2[7:1];
    end
  end

  // no transfer is taken while reset is held
  assign sample.ready = (state == ST_IDLE) && !rst;

  // --- configuration writes ---
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal0_deg_x8 <= '0;
      temp_cal1_deg_x8 <= '0;
      temp_cal0_raw    <= '0;
      temp_cal1_raw    <= '0;
      hum_cal0_rh_x2   <= '0;
      hum_cal1_rh_x2   <= '0;
      hum_cal0_raw     <= '0;
      hum_cal1_raw     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP_CAL0_DEG: temp_cal0_deg_x8 <= cfg_data[9:0];
        REG_TEMP_CAL1_DEG: temp_cal1_deg_x8 <= cfg_data[9:0];
        REG_TEMP_CAL0_RAW: temp_cal0_raw    <= cfg_data;
        REG_TEMP_CAL1_RAW: temp_cal1_raw    <= cfg_data;
        REG_HUM_CAL0_RH:   hum_cal0_rh_x2   <= cfg_data[7:0];
        REG_HUM_CAL1_RH:   hum_cal1_rh_x2   <= cfg_data[7:0];
        REG_HUM_CAL0_RAW:  hum_cal0_raw     <= cfg_data;
        REG_HUM_CAL1_RAW:  hum_cal1_raw     <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- shared multiplier: operands chosen by the sequencer step ---
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_A: begin
        mul_a = OPND_W'(dr);
        mul_b = OPND_W'(dp);
      end
      ST_MUL_B: begin
        mul_a = {{(OPND_W-7){1'b0}}, p0};
        mul_b = OPND_W'(den);
      end
      ST_MUL_C: begin
        mul_a = {{(OPND_W-DVS_W){1'b0}}, aden};
        mul_b = MAX_Q;
      end
      ST_MUL_D: begin
        mul_a = {{(OPND_W-DVS_W){1'b0}}, aden};
        mul_b = TEMP_MIN_Q;
      end
      default: ;
    endcase
  end

  htint_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // --- serial divider: |num| / |den| ---
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_q;
  logic [33:0]      num_neg;
  logic             div_go;

  assign num_neg      = -num;
  assign div_dividend = num[33] ? num_neg[DIV_W-1:0] : num[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= (state == ST_MUL_D);
    end
  end

  // the product for the lower temperature limit lands during the start cycle
  assign div_ctrl.start = div_go;

  htint_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (aden),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // --- result formation: sign, clamp, window ---
  logic               q_neg;
  logic               sat_pos, sat_neg;
  logic [31:0]        q_mag;
  logic signed [31:0] conv;
  logic signed [34:0] num_x;
  logic signed [34:0] hi_x;
  logic signed [34:0] lo_sum;
  logic               ok;
  logic               slot_free;
  logic [15:0]        held_sel;

  always_comb begin
    q_neg   = num[33];
    q_mag   = div_q[31:0];
    sat_pos = !q_neg && (div_q[32:31] != 2'b00);
    sat_neg = q_neg && (div_q[32] || (div_q[31] && (div_q[30:0] != '0)));
    if (fault) begin
      conv = '0;
    end else if (sat_pos) begin
      conv = 32'sh7FFF_FFFF;
    end else if (sat_neg) begin
      conv = 32'sh8000_0000;
    end else if (q_neg) begin
      conv = -q_mag;
    end else begin
      conv = q_mag;
    end

    // exact rational window test on num against limit * |den|
    num_x  = {num[33], num};
    hi_x   = {3'b000, lim_hi};
    lo_sum = num_x + {3'b000, lim_lo};
    if (fault) begin
      ok = 1'b0;
    end else if (kind) begin
      ok = (num_x < hi_x) && !lo_sum[34] && (lo_sum != '0);
    end else begin
      ok = !num[33] && (num_x <= hi_x);
    end

    held_sel = kind ? last_temperature : last_humidity;
  end

  assign slot_free = !result.valid || result.ready;

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:     if (sample.valid) state <= ST_MUL_A;
        ST_MUL_A:    state <= (den == '0) ? ST_FINISH : ST_MUL_B;
        ST_MUL_B:    state <= ST_MUL_C;
        ST_MUL_C:    state <= ST_MUL_D;
        ST_MUL_D:    state <= ST_DIV_WAIT;
        ST_DIV_WAIT: if (div_stat.done) state <= ST_FINISH;
        ST_FINISH:   if (slot_free) state <= ST_IDLE;
        default:     state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, loaded step by step
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        kind  <= sample.func;
        dr    <= 17'(sample.raw_sample) - 17'(sel_r0);
        den   <= 17'(sel_r1) - 17'(sel_r0);
        dp    <= $signed({1'b0, sel_p1}) - $signed({1'b0, sel_p0});
        p0    <= sel_p0;
      end
      ST_MUL_A: begin
        fault <= (den == '0);
        aden  <= den[16] ? DVS_W'(-den) : den[DVS_W-1:0];
      end
      ST_MUL_B: begin
        prod1 <= mul_p[25:0];
      end
      ST_MUL_C: begin
        sum <= prod1 + mul_p[25:0];
      end
      ST_MUL_D: begin
        lim_hi <= mul_p[31:0];
        num    <= den[16] ? -{sum, 8'h00} : {sum, 8'h00};
      end
      ST_DIV_WAIT: begin
        lim_lo <= div_go ? mul_p[31:0] : lim_lo;
      end
      default: ;
    endcase
  end

  // last good readings
  always_ff @(posedge clk) begin
    if (rst) begin
      last_humidity    <= '0;
      last_temperature <= '0;
    end else if (state == ST_FINISH && slot_free && ok) begin
      if (kind) begin
        last_temperature <= conv[15:0];
      end else begin
        last_humidity <= conv[15:0];
      end
    end
  end

  // output register: the next sample may be taken while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_FINISH && slot_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && slot_free) begin
      result.kind         <= kind;
      result.converted    <= conv;
      result.accepted     <= ok;
      result.divide_fault <= fault;
      result.held_value   <= ok ? conv[15:0] : held_sel;
    end
  end

endmodule

@@ rtl/htint_mul.sv @@
// ----------------------------------------------------------------------------
// htint_mul
// Shared signed multiplier, product registered.
// ----------------------------------------------------------------------------
module htint_mul import htint_pkg::*; (
  input  logic                     clk,
  input  logic signed [OPND_W-1:0] a,
  input  logic signed [OPND_W-1:0] b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/htint_div.sv @@
// ----------------------------------------------------------------------------
// htint_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htint_div import htint_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem, quotient[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          running   <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      if (!diff[DVS_W]) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ tb/sv/humidity_temperature_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// humidity_temperature_interpolator_tb
// Self-checking bench for the two-point humidity/temperature calibrator. A
// scoreboard holds a mirror of the calibration registers and last readings,
// predicts every result when its sample transfer is seen, and compares the
// result stream field by field. Directed window and rounding cases come
// first, then randomised calibrations with varied sender/receiver pacing.
// ----------------------------------------------------------------------------
module humidity_temperature_interpolator_tb;
  import htint_pkg::*;

  // quantity selector carried by func/kind
  typedef enum logic {QTY_HUM = 1'b0, QTY_TEMP = 1'b1} qty_t;

  typedef enum int {CAL_REAL, CAL_RANDOM, CAL_EXTREME} cal_style_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    qty_t               kind;
    logic signed [31:0] converted;
    logic               accepted;
    logic               divide_fault;
    logic signed [15:0] held_value;
  } reading_t;

  // window limits, Q8.8
  localparam longint HUM_TOP_Q   = 25600;
  localparam longint TEMP_TOP_Q  = 25600;
  localparam longint TEMP_LOW_Q  = -15360;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 125;
  localparam int     DRAIN_TAIL  = 64;    // idle tail after the last drain

  // --------------------------------------------------------------------------
  // Scoreboard: calibration mirror, last-good readings and expected results
  // --------------------------------------------------------------------------
  class reading_scoreboard;
    logic [9:0]         t_deg0, t_deg1;
    logic signed [15:0] t_raw0, t_raw1;
    logic [7:0]         h_rh0, h_rh1;
    logic signed [15:0] h_raw0, h_raw1;
    logic signed [15:0] last_hum, last_temp;
    reading_t           expected_readings[$];
    int                 errors, checked, kept_hum, kept_temp, faults;

    function new();
      t_deg0 = '0; t_deg1 = '0; t_raw0 = '0; t_raw1 = '0;
      h_rh0 = '0; h_rh1 = '0; h_raw0 = '0; h_raw1 = '0;
      last_hum = '0; last_temp = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_TEMP_CAL0_DEG: t_deg0 = v[9:0];
        REG_TEMP_CAL1_DEG: t_deg1 = v[9:0];
        REG_TEMP_CAL0_RAW: t_raw0 = v;
        REG_TEMP_CAL1_RAW: t_raw1 = v;
        REG_HUM_CAL0_RH:   h_rh0  = v[7:0];
        REG_HUM_CAL1_RH:   h_rh1  = v[7:0];
        REG_HUM_CAL0_RAW:  h_raw0 = v;
        REG_HUM_CAL1_RAW:  h_raw1 = v;
        default: ;
      endcase
    endfunction

    // Interpolate one sample; window test on the exact ratio num/den.
    function void note_sample(qty_t q, logic signed [15:0] raw);
      longint   p0, p1, r0, r1, den, num, quot;
      reading_t r;
      if (q == QTY_TEMP) begin
        p0 = longint'(t_deg0 >> 3);
        p1 = longint'(t_deg1 >> 3);
        r0 = longint'(t_raw0);
        r1 = longint'(t_raw1);
      end else begin
        p0 = longint'(h_rh0 >> 1);
        p1 = longint'(h_rh1 >> 1);
        r0 = longint'(h_raw0);
        r1 = longint'(h_raw1);
      end
      den            = r1 - r0;
      r.kind         = q;
      r.converted    = '0;
      r.accepted     = 1'b0;
      r.divide_fault = (den == 0);
      if (den != 0) begin
        num = (longint'(raw) - r0) * (p1 - p0) * 256 + p0 * 256 * den;
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        quot = num / den;                  // truncates toward zero
        if (quot > SAT_HI) quot = SAT_HI;
        if (quot < SAT_LO) quot = SAT_LO;
        r.converted = quot[31:0];
        if (q == QTY_TEMP) begin
          r.accepted = (num > TEMP_LOW_Q * den) && (num < TEMP_TOP_Q * den);
          if (r.accepted) last_temp = quot[15:0];
        end else begin
          r.accepted = (num >= 0) && (num <= HUM_TOP_Q * den);
          if (r.accepted) last_hum = quot[15:0];
        end
      end
      r.held_value = (q == QTY_TEMP) ? last_temp : last_hum;
      expected_readings.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        if (errors < 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d",
                   $time, field, $signed(e), $signed(a));
        errors++;
      end
    endfunction

    function void check_result(reading_t got);
      reading_t e;
      if (expected_readings.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                   $time, got.kind, got.converted);
        errors++;
        return;
      end
      e = expected_readings.pop_front();
      checked++;
      if (e.divide_fault) faults++;
      if (e.accepted && e.kind == QTY_HUM) kept_hum++;
      if (e.accepted && e.kind == QTY_TEMP) kept_temp++;
      compare("kind",         e.kind,         got.kind);
      compare("converted",    e.converted,    got.converted);
      compare("accepted",     e.accepted,     got.accepted);
      compare("divide_fault", e.divide_fault, got.divide_fault);
      compare("held_value",   e.held_value,   got.held_value);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   src_idle_pct;     // chance per cycle that the sender holds off
  int                   snk_stall_pct;    // chance per cycle that ready is low
  int                   cal_sets;
  reading_scoreboard    sb;

  htint_in_if  sample_ch ();
  htint_out_if result_ch ();

  always #1 clk = ~clk;

  humidity_temperature_interpolator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // Receiver: one fresh ready decision per edge.
  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Result monitor: values read just after the edge are those the edge saw.
  always @(posedge clk) begin
    reading_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.kind         = qty_t'(result_ch.kind);
      got.converted    = result_ch.converted;
      got.accepted     = result_ch.accepted;
      got.divide_fault = result_ch.divide_fault;
      got.held_value   = result_ch.held_value;
      sb.check_result(got);
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------
  function automatic void set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 70; snk_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 70; end
      default:       begin src_idle_pct = 26; snk_stall_pct = 26; end
    endcase
  endfunction

  // valid stays up between back-to-back samples; it drops only for an idle gap or a
  // drain, so it never gets two updates in one time step
  task automatic send_sample(qty_t q, logic signed [15:0] raw);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.func       <= q;
    sample_ch.raw_sample <= raw;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(q, raw);
  endtask

  // Stop sending and wait until every expected result has been transferred.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_readings.size() != 0);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Full recalibration; only done with the block drained.
  task automatic load_cal(logic [9:0] td0, logic [9:0] td1,
                          logic signed [15:0] tr0, logic signed [15:0] tr1,
                          logic [7:0] hr0, logic [7:0] hr1,
                          logic signed [15:0] hw0, logic signed [15:0] hw1);
    wait_drained();
    put_reg(REG_TEMP_CAL0_DEG, 16'(td0));
    put_reg(REG_TEMP_CAL1_DEG, 16'(td1));
    put_reg(REG_TEMP_CAL0_RAW, tr0);
    put_reg(REG_TEMP_CAL1_RAW, tr1);
    put_reg(REG_HUM_CAL0_RH,   16'(hr0));
    put_reg(REG_HUM_CAL1_RH,   16'(hr1));
    put_reg(REG_HUM_CAL0_RAW,  hw0);
    put_reg(REG_HUM_CAL1_RAW,  hw1);
    cfg_we <= 1'b0;
    cal_sets++;
  endtask

  function automatic logic [15:0] pick_edge16();
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic program_random_cal(cal_style_t style);
    logic [9:0]         td0, td1;
    logic [7:0]         hr0, hr1;
    logic signed [15:0] tr0, tr1, hw0, hw1;
    int                 base, span;
    case (style)
      CAL_REAL: begin
        // plausible sensor: low point a few degrees / percent, high point well up
        td0  = 10'($urandom_range(0, 240));
        td1  = 10'($urandom_range(480, 1023));
        base = int'($urandom_range(0, 40000)) - 20000;
        span = int'($urandom_range(1, 12000));
        if ($urandom_range(1)) span = -span;
        tr0  = 16'(base);
        tr1  = 16'(base + span);
        hr0  = 8'($urandom_range(0, 60));
        hr1  = 8'($urandom_range(140, 255));
        base = int'($urandom_range(0, 40000)) - 20000;
        span = int'($urandom_range(1, 12000));
        if ($urandom_range(1)) span = -span;
        hw0  = 16'(base);
        hw1  = 16'(base + span);
        if ($urandom_range(9) == 0) tr1 = tr0;   // equal pair: divide fault
        if ($urandom_range(9) == 0) hw1 = hw0;
      end
      CAL_RANDOM: begin
        td0 = 10'($urandom_range(1023)); td1 = 10'($urandom_range(1023));
        hr0 = 8'($urandom_range(255));   hr1 = 8'($urandom_range(255));
        tr0 = 16'($urandom()); tr1 = 16'($urandom());
        hw0 = 16'($urandom()); hw1 = 16'($urandom());
      end
      default: begin
        td0 = $urandom_range(1) ? 10'h3FF : 10'h000;
        td1 = $urandom_range(1) ? 10'h3FF : 10'h000;
        hr0 = $urandom_range(1) ? 8'hFF : 8'h00;
        hr1 = $urandom_range(1) ? 8'hFF : 8'h00;
        tr0 = pick_edge16(); tr1 = pick_edge16();
        hw0 = pick_edge16(); hw1 = pick_edge16();
      end
    endcase
    load_cal(td0, td1, tr0, tr1, hr0, hr1, hw0, hw1);
  endtask

  // Mostly samples around the calibrated span for CAL_REAL (interpolation and modest
  // extrapolation, so the window edges get hit), some wild and extreme ones; else only those.
  function automatic logic signed [15:0] pick_raw(qty_t q, cal_style_t style);
    longint r0, r1, span, v;
    int     sel;
    r0  = (q == QTY_TEMP) ? longint'(sb.t_raw0) : longint'(sb.h_raw0);
    r1  = (q == QTY_TEMP) ? longint'(sb.t_raw1) : longint'(sb.h_raw1);
    sel = $urandom_range(99);
    if (sel < 8 || (style == CAL_EXTREME && sel < 60)) begin
      case ($urandom_range(5))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        3:       return -16'sd1;
        4:       return r0[15:0];
        default: return r1[15:0];
      endcase
    end
    if (sel < 25 || style != CAL_REAL) return 16'($urandom());
    span = (r1 > r0) ? r1 - r0 : r0 - r1;
    span = span + 4;
    v    = ((r0 < r1) ? r0 : r1) - span + longint'($urandom_range(0, 32'(3 * span)));
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cal_style_t plan [RAND_PHASES];
    qty_t       q;
    sb                   = new();
    cal_sets             = 0;
    plan                 = '{CAL_REAL, CAL_REAL, CAL_RANDOM, CAL_REAL,
                             CAL_EXTREME, CAL_REAL, CAL_RANDOM, CAL_REAL};
    set_idling(IDLE_NONE);
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.func       <= QTY_HUM;
    sample_ch.raw_sample <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: both raw pairs equal, so both quantities fault.
    send_sample(QTY_HUM, 16'sd0);
    send_sample(QTY_TEMP, 16'sh7FFF);

    // Unit slope, y = raw. Humidity window is closed, temperature open.
    // 807 eighths shifts down to 100 degrees, dropping the fraction bits.
    load_cal(10'd0, 10'd807, 16'sd0, 16'sd100, 8'd0, 8'd200, 16'sd0, 16'sd100);
    send_sample(QTY_HUM, 16'sd0);
    send_sample(QTY_HUM, 16'sd100);
    send_sample(QTY_HUM, 16'sd101);
    send_sample(QTY_HUM, -16'sd1);
    send_sample(QTY_HUM, 16'sd50);
    send_sample(QTY_TEMP, -16'sd60);
    send_sample(QTY_TEMP, -16'sd59);
    send_sample(QTY_TEMP, 16'sd99);
    send_sample(QTY_TEMP, 16'sd100);
    send_sample(QTY_TEMP, 16'sh8000);
    send_sample(QTY_TEMP, 16'sh7FFF);

    // Falling pairs (negative denominator), thirds that need truncation
    // toward zero on both signs, register maxima and raw extremes.
    load_cal(10'd1023, 10'd0, 16'sd3, 16'sd0, 8'd255, 8'd0, 16'sh7FFF, 16'sh8000);
    send_sample(QTY_TEMP, 16'sd4);
    send_sample(QTY_TEMP, 16'sd1);
    send_sample(QTY_TEMP, -16'sd2);
    send_sample(QTY_TEMP, 16'sh7FFF);
    send_sample(QTY_TEMP, 16'sh8000);
    send_sample(QTY_HUM, 16'sh8000);
    send_sample(QTY_HUM, 16'sh7FFF);
    send_sample(QTY_HUM, 16'sd0);

    // Random phases: each gets a new calibration and a pacing mode.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      program_random_cal(plan[ph]);
      set_idling(idle_mode_t'(ph % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then hold off until the pipe is empty
        if ($urandom_range(49) == 0) wait_drained();
        q = qty_t'($urandom_range(1));
        send_sample(q, pick_raw(q, plan[ph]));
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Checked %0d results over %0d calibration sets: %0d humidity and %0d",
             sb.checked, cal_sets, sb.kept_hum, sb.kept_temp);
    $display("temperature readings kept, %0d divide faults, %0d mismatches",
             sb.faults, sb.errors);
    if (sb.errors == 0 && sb.expected_readings.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
